>>> design/sct_pkg.sv
`default_nettype none

package sct_pkg;

    // Default limits for the top-level parameters
    localparam int unsigned MAX_LEXEME_LENGTH_DEF = 4095;
    localparam int unsigned MAX_LINE_COUNT_DEF    = 65535;

    // Output queue depth; an item can add two tokens at once
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_source;
    } src_item_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [31:0] start_offset;
        logic [11:0] lexeme_length;
        logic        last_of_run;
    } tok_item_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_FRAC,
        MODE_EQ,
        MODE_LT,
        MODE_GT,
        MODE_BANG
    } mode_t;

    // Token kinds
    localparam logic [4:0] KIND_EOF     = 5'd0;
    localparam logic [4:0] KIND_IDENT   = 5'd1;
    localparam logic [4:0] KIND_NUMBER  = 5'd2;
    localparam logic [4:0] KIND_KW_BASE = 5'd3;
    localparam logic [4:0] KIND_PLUS    = 5'd7;
    localparam logic [4:0] KIND_STAR    = 5'd8;
    localparam logic [4:0] KIND_LBRACE  = 5'd9;
    localparam logic [4:0] KIND_RBRACE  = 5'd10;
    localparam logic [4:0] KIND_LPAREN  = 5'd11;
    localparam logic [4:0] KIND_RPAREN  = 5'd12;
    localparam logic [4:0] KIND_SEMI    = 5'd13;
    localparam logic [4:0] KIND_COMMA   = 5'd14;
    localparam logic [4:0] KIND_ASSIGN  = 5'd15;
    localparam logic [4:0] KIND_EQ_EQ   = 5'd16;
    localparam logic [4:0] KIND_LT      = 5'd17;
    localparam logic [4:0] KIND_LT_EQ   = 5'd18;
    localparam logic [4:0] KIND_GT      = 5'd19;
    localparam logic [4:0] KIND_GT_EQ   = 5'd20;
    localparam logic [4:0] KIND_NOT_EQ  = 5'd21;
    localparam logic [4:0] KIND_UNKNOWN = 5'd22;

    // Keyword slots
    localparam logic [1:0] KW_INT    = 2'd0;
    localparam logic [1:0] KW_FLOAT  = 2'd1;
    localparam logic [1:0] KW_VEC3   = 2'd2;
    localparam logic [1:0] KW_RETURN = 2'd3;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] len;
        case (k)
            KW_INT:    len = 3'd3;
            KW_FLOAT:  len = 3'd5;
            KW_VEC3:   len = 3'd4;
            KW_RETURN: len = 3'd6;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    // Character idx of keyword k, first character in the top byte
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
        logic [47:0] txt;
        logic [7:0]  ch;
        case (k)
            KW_INT:    txt = {"int", 24'h0};
            KW_FLOAT:  txt = {"float", 8'h0};
            KW_VEC3:   txt = {"vec3", 16'h0};
            KW_RETURN: txt = "return";
            default:   txt = '0;
        endcase
        case (idx)
            3'd0:    ch = txt[47:40];
            3'd1:    ch = txt[39:32];
            3'd2:    ch = txt[31:24];
            3'd3:    ch = txt[23:16];
            3'd4:    ch = txt[15:8];
            3'd5:    ch = txt[7:0];
            default: ch = 8'h0;
        endcase
        return ch;
    endfunction

    // Drop every keyword that cannot take character c at position pos
    function automatic logic [3:0] kw_match(input logic [3:0] mask, input logic [11:0] pos,
                                           input logic [7:0] c);
        logic [3:0] keep;
        for (int k = 0; k < 4; k++)
        begin
            keep[k] = mask[k] && (pos < {9'd0, kw_len(2'(k))})
                      && (kw_char(2'(k), pos[2:0]) == c);
        end
        return keep;
    endfunction

endpackage

`default_nettype wire

>>> design/source_char_tokenizer.sv
// Streaming tokenizer: source bytes in, tokens out.
// src channel: one item per source byte (char_code), or an end marker
//   (end_of_source, or a zero byte) that flushes the pending token and
//   adds an end-of-file token, then returns the position to line 1,
//   column 1, offset 0.
// tok channel: one item per token with kind, start line/column/offset and
//   length; last_of_run marks the final token caused by one source item.
// Timing: a byte is taken into the input register and classified there when
//   it is consumed; its tokens land in the queue at the end of the cycle in
//   which it is consumed, and tok_valid rises once the queue holds a token.
// Throughput: one source item per cycle while the queue has two free slots.
//   An item makes zero, one or two tokens; the tok side drains one token per
//   cycle, so a run of two-token items is limited by the output port.
// A four-entry token queue parts the two sides. The input register is only
//   consumed while the queue has two free slots; when the receiver stalls
//   the queue fills, the input register holds and src_ready drops.
// Reset empties the input register and the queue and puts the scanner in
//   the idle mode at line 1, column 1, offset 0.
`default_nettype none

module source_char_tokenizer #(
    parameter int unsigned MAX_LEXEME_LENGTH = sct_pkg::MAX_LEXEME_LENGTH_DEF,
    parameter int unsigned MAX_LINE_COUNT    = sct_pkg::MAX_LINE_COUNT_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               src_valid,
    output logic              src_ready,
    input  sct_pkg::src_item_t src_item,
    output logic              tok_valid,
    input  wire               tok_ready,
    output sct_pkg::tok_item_t tok_item
);

    // Saturation limits
    localparam logic [15:0] LineCap = (MAX_LINE_COUNT < 65535) ? 16'(MAX_LINE_COUNT) : 16'hFFFF;
    localparam logic [11:0] LenCap  = (MAX_LEXEME_LENGTH < 4095) ?
                                      12'(MAX_LEXEME_LENGTH) : 12'hFFF;

    localparam int unsigned QDepth = sct_pkg::QUEUE_DEPTH;
    localparam int unsigned PtrW   = $clog2(QDepth);
    localparam int unsigned CntW   = $clog2(QDepth + 1);
    localparam logic [CntW-1:0] RoomLimit = CntW'(QDepth - 2);

    // Input register
    logic               in_valid_reg;
    sct_pkg::src_item_t in_item_reg;
    logic               consume;

    // Scanner state
    sct_pkg::mode_t mode_reg, mode_next;
    logic [3:0]     mask_reg, mask_next;
    logic [15:0]    tok_line_reg, tok_line_next;
    logic [15:0]    tok_col_reg, tok_col_next;
    logic [31:0]    tok_off_reg, tok_off_next;
    logic [11:0]    pend_len_reg, pend_len_next;
    logic [15:0]    cur_line_reg, cur_line_next;
    logic [15:0]    cur_col_reg, cur_col_next;
    logic [31:0]    cur_off_reg, cur_off_next;

    // Token queue
    sct_pkg::tok_item_t q_reg [QDepth];
    logic [PtrW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]    count_reg;
    logic               pop;

    // Per-item classification
    logic [7:0]         c;
    logic               eos;
    logic [15:0]        adv_line, adv_col;
    logic [31:0]        adv_off;
    logic [11:0]        pend_inc;
    logic               flush_valid;
    logic [4:0]         flush_kind;
    logic [4:0]         pair_kind;
    logic [4:0]         single_kind;
    logic               done;
    logic               first_valid, second_valid;
    sct_pkg::tok_item_t first_tok, second_tok;
    sct_pkg::tok_item_t res0, res1;
    logic [1:0]         res_count;

    function automatic sct_pkg::tok_item_t mk_tok(input logic [4:0] kind,
                                                  input logic [15:0] line,
                                                  input logic [15:0] col,
                                                  input logic [31:0] off,
                                                  input logic [11:0] len);
        sct_pkg::tok_item_t t;
        t.token_kind    = kind;
        t.start_line    = line;
        t.start_column  = col;
        t.start_offset  = off;
        t.lexeme_length = len;
        t.last_of_run   = 1'b0;
        return t;
    endfunction

    // Hold an item until the queue can take two tokens
    assign consume   = in_valid_reg && (count_reg <= RoomLimit);
    assign src_ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (src_ready)
        begin
            in_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_ready && src_valid)
        begin
            in_item_reg <= src_item;
        end
    end

    assign c   = in_item_reg.char_code;
    assign eos = in_item_reg.end_of_source || (c == 8'd0);

    // Position after this byte, saturating
    assign adv_off  = (cur_off_reg != 32'hFFFF_FFFF) ? cur_off_reg + 32'd1 : cur_off_reg;
    assign adv_line = (c == 8'h0A && cur_line_reg < LineCap) ? cur_line_reg + 16'd1
                                                             : cur_line_reg;
    assign adv_col  = (c == 8'h0A) ? 16'd1 :
                      (cur_col_reg < LineCap) ? cur_col_reg + 16'd1 : cur_col_reg;
    assign pend_inc = (pend_len_reg < LenCap) ? pend_len_reg + 12'd1 : pend_len_reg;

    // Kind of the pending token if it were flushed now
    always_comb
    begin
        flush_valid = 1'b1;
        flush_kind  = sct_pkg::KIND_EOF;
        pair_kind   = sct_pkg::KIND_NOT_EQ;
        case (mode_reg)
            sct_pkg::MODE_IDENT:
            begin
                flush_kind = sct_pkg::KIND_IDENT;
                for (int k = 0; k < 4; k++)
                begin
                    if (mask_reg[k] && pend_len_reg == {9'd0, sct_pkg::kw_len(2'(k))})
                    begin
                        flush_kind = sct_pkg::KIND_KW_BASE + 5'(k);
                    end
                end
            end
            sct_pkg::MODE_INT, sct_pkg::MODE_FRAC: flush_kind = sct_pkg::KIND_NUMBER;
            sct_pkg::MODE_EQ:
            begin
                flush_kind = sct_pkg::KIND_ASSIGN;
                pair_kind  = sct_pkg::KIND_EQ_EQ;
            end
            sct_pkg::MODE_LT:
            begin
                flush_kind = sct_pkg::KIND_LT;
                pair_kind  = sct_pkg::KIND_LT_EQ;
            end
            sct_pkg::MODE_GT:
            begin
                flush_kind = sct_pkg::KIND_GT;
                pair_kind  = sct_pkg::KIND_GT_EQ;
            end
            sct_pkg::MODE_BANG: flush_kind = sct_pkg::KIND_UNKNOWN;
            default:            flush_valid = 1'b0;
        endcase
    end

    // Kind of a one-byte token from idle
    always_comb
    begin
        case (c)
            "+":     single_kind = sct_pkg::KIND_PLUS;
            "*":     single_kind = sct_pkg::KIND_STAR;
            "{":     single_kind = sct_pkg::KIND_LBRACE;
            "}":     single_kind = sct_pkg::KIND_RBRACE;
            "(":     single_kind = sct_pkg::KIND_LPAREN;
            ")":     single_kind = sct_pkg::KIND_RPAREN;
            ";":     single_kind = sct_pkg::KIND_SEMI;
            ",":     single_kind = sct_pkg::KIND_COMMA;
            default: single_kind = sct_pkg::KIND_UNKNOWN;
        endcase
    end

    // Next state and the tokens of this item
    always_comb
    begin
        mode_next     = mode_reg;
        mask_next     = mask_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        tok_off_next  = tok_off_reg;
        pend_len_next = pend_len_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        cur_off_next  = cur_off_reg;
        done          = 1'b0;
        first_valid   = 1'b0;
        second_valid  = 1'b0;
        first_tok     = mk_tok(flush_kind, tok_line_reg, tok_col_reg, tok_off_reg,
                               pend_len_reg);
        second_tok    = mk_tok(single_kind, cur_line_reg, cur_col_reg, cur_off_reg, 12'd1);

        if (consume)
        begin
            if (eos)
            begin
                // Flush, report end of file, return to reset position
                first_valid   = flush_valid;
                second_valid  = 1'b1;
                second_tok    = mk_tok(sct_pkg::KIND_EOF, cur_line_reg, cur_col_reg,
                                       cur_off_reg, 12'd0);
                mode_next     = sct_pkg::MODE_IDLE;
                mask_next     = 4'hF;
                tok_line_next = 16'd1;
                tok_col_next  = 16'd1;
                tok_off_next  = 32'd0;
                pend_len_next = 12'd0;
                cur_line_next = 16'd1;
                cur_col_next  = 16'd1;
                cur_off_next  = 32'd0;
            end
            else
            begin
                // Try to continue the pending token
                case (mode_reg)
                    sct_pkg::MODE_IDENT:
                    begin
                        if (sct_pkg::is_ident_char(c))
                        begin
                            mask_next     = sct_pkg::kw_match(mask_reg, pend_len_reg, c);
                            pend_len_next = pend_inc;
                            done          = 1'b1;
                        end
                    end
                    sct_pkg::MODE_INT:
                    begin
                        if (sct_pkg::is_digit(c))
                        begin
                            pend_len_next = pend_inc;
                            done          = 1'b1;
                        end
                        else if (c == ".")
                        begin
                            pend_len_next = pend_inc;
                            mode_next     = sct_pkg::MODE_FRAC;
                            done          = 1'b1;
                        end
                    end
                    sct_pkg::MODE_FRAC:
                    begin
                        if (sct_pkg::is_digit(c))
                        begin
                            pend_len_next = pend_inc;
                            done          = 1'b1;
                        end
                    end
                    sct_pkg::MODE_EQ, sct_pkg::MODE_LT, sct_pkg::MODE_GT,
                    sct_pkg::MODE_BANG:
                    begin
                        if (c == "=")
                        begin
                            second_valid  = 1'b1;
                            second_tok    = mk_tok(pair_kind, tok_line_reg, tok_col_reg,
                                                   tok_off_reg, 12'd2);
                            mode_next     = sct_pkg::MODE_IDLE;
                            pend_len_next = 12'd0;
                            done          = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (!done)
                begin
                    // Flush the pending token, then treat the byte from idle
                    first_valid = flush_valid;
                    if (flush_valid)
                    begin
                        mode_next     = sct_pkg::MODE_IDLE;
                        mask_next     = 4'hF;
                        pend_len_next = 12'd0;
                    end
                    if (!sct_pkg::is_space(c))
                    begin
                        if (sct_pkg::is_alpha(c) || c == "_" || sct_pkg::is_digit(c)
                            || c == "=" || c == "<" || c == ">" || c == "!")
                        begin
                            tok_line_next = cur_line_reg;
                            tok_col_next  = cur_col_reg;
                            tok_off_next  = cur_off_reg;
                            mask_next     = 4'hF;
                            pend_len_next = 12'd1;
                            if (sct_pkg::is_digit(c))
                            begin
                                mode_next = sct_pkg::MODE_INT;
                            end
                            else if (c == "=")
                            begin
                                mode_next = sct_pkg::MODE_EQ;
                            end
                            else if (c == "<")
                            begin
                                mode_next = sct_pkg::MODE_LT;
                            end
                            else if (c == ">")
                            begin
                                mode_next = sct_pkg::MODE_GT;
                            end
                            else if (c == "!")
                            begin
                                mode_next = sct_pkg::MODE_BANG;
                            end
                            else
                            begin
                                mode_next = sct_pkg::MODE_IDENT;
                                mask_next = sct_pkg::kw_match(4'hF, 12'd0, c);
                            end
                        end
                        else
                        begin
                            second_valid = 1'b1;
                        end
                    end
                end

                // Every non-end byte advances the position
                cur_line_next = adv_line;
                cur_col_next  = adv_col;
                cur_off_next  = adv_off;
            end
        end
    end

    // Pack tokens in order and mark the last one
    always_comb
    begin
        if (first_valid)
        begin
            res0      = first_tok;
            res1      = second_tok;
            res_count = second_valid ? 2'd2 : 2'd1;
        end
        else
        begin
            res0      = second_tok;
            res1      = second_tok;
            res_count = second_valid ? 2'd1 : 2'd0;
        end
        if (res_count == 2'd2)
        begin
            res1.last_of_run = 1'b1;
        end
        else
        begin
            res0.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= sct_pkg::MODE_IDLE;
            mask_reg     <= 4'hF;
            tok_line_reg <= 16'd1;
            tok_col_reg  <= 16'd1;
            tok_off_reg  <= 32'd0;
            pend_len_reg <= 12'd0;
            cur_line_reg <= 16'd1;
            cur_col_reg  <= 16'd1;
            cur_off_reg  <= 32'd0;
        end
        else
        begin
            mode_reg     <= mode_next;
            mask_reg     <= mask_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            tok_off_reg  <= tok_off_next;
            pend_len_reg <= pend_len_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            cur_off_reg  <= cur_off_next;
        end
    end

    // Token queue
    assign tok_valid = (count_reg != '0);
    assign tok_item  = q_reg[rd_ptr_reg];
    assign pop       = tok_valid && tok_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (consume)
            begin
                wr_ptr_reg <= wr_ptr_reg + PtrW'(res_count);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_reg + (consume ? CntW'(res_count) : CntW'(0))
                         - (pop ? CntW'(1) : CntW'(0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && res_count != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (consume && res_count == 2'd2)
        begin
            q_reg[wr_ptr_reg + PtrW'(1)] <= res1;
        end
    end

endmodule

`default_nettype wire
